// ===== hdl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// Task table scheduler package
// Shared types and codes for the task slot table, the stack allocator and the
// round-robin tick scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Operation carried by an input transaction.
  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_START  = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Result codes.
  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_NO_STACK    = 3'd1,
    STATUS_NOT_CREATED = 3'd2,
    STATUS_RANGE       = 3'd3,
    STATUS_NO_SLOT     = 3'd4,
    STATUS_NO_READY    = 3'd5
  } status_t;

  localparam int unsigned TaskIdW = 8;
  localparam int unsigned DescW   = 16;
  localparam int unsigned IdxW    = 3;

  // One request handed from the port side to the sequencer.
  typedef struct packed {
    kind_t              kind;
    logic [TaskIdW-1:0] task_id;
    logic [DescW-1:0]   descriptor;
  } req_t;

  // One finished result, with the strobe that marks it.
  typedef struct packed {
    logic             done;
    logic [2:0]       status;
    logic [IdxW-1:0]  slot;
    logic [IdxW-1:0]  stack_index;
    logic [DescW-1:0] entry_handle;
    logic             switched;
    logic [IdxW-1:0]  from_task;
    logic [IdxW-1:0]  to_task;
  } rsp_t;

endpackage

// ===== hdl/tts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/tts_seq.sv =====
// ----------------------------------------------------------------------------
// Task table scheduler sequencer
// Holds the slot table and stack bitmap and runs every scan through one
// shared probe: one slot or one stack is examined per cycle.
// ----------------------------------------------------------------------------
module tts_seq #(
  parameter int unsigned NUM_SLOTS  = 8,
  parameter int unsigned NUM_STACKS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  tts_pkg::req_t req,
  output logic          busy,
  output tts_pkg::rsp_t rsp
);

  localparam int unsigned SlotW = $clog2(NUM_SLOTS);
  localparam int unsigned StkW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned MaxN  = (NUM_SLOTS > NUM_STACKS) ? NUM_SLOTS : NUM_STACKS;
  localparam int unsigned CntW  = $clog2(MaxN + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_CHECK,
    S_STACK,
    S_TICK
  } state_t;

  state_t                           state, state_next;
  logic [SlotW-1:0]                 ptr, ptr_next, ptr_adv, cur_adv;
  logic [CntW-1:0]                  step, step_next;
  logic [SlotW-1:0]                 cur, cur_next;
  logic [NUM_SLOTS-1:0]             created_q, ready_q;
  logic [NUM_STACKS-1:0]            bitmap;
  logic [tts_pkg::TaskIdW-1:0]      tid_q;
  logic [tts_pkg::DescW-1:0]        desc_q;
  logic [SlotW-1:0]                 tid_idx;
  logic [tts_pkg::DescW-1:0]        rd_data;
  logic                             probe, last_slot, last_stack;
  logic                             fin, set_created, set_ready, ram_wr;
  tts_pkg::rsp_t                    res_next;

  assign tid_idx    = tid_q[SlotW-1:0];
  assign ptr_adv    = (ptr == LastSlot) ? '0 : ptr + 1'b1;
  assign cur_adv    = (cur == LastSlot) ? '0 : cur + 1'b1;
  assign last_slot  = (step == CntW'(NUM_SLOTS - 1));
  assign last_stack = (step == CntW'(NUM_STACKS - 1));
  assign busy       = (state != S_IDLE) || rsp.done;
  assign ram_wr     = (state == S_CREATE) && probe;

  // The descriptor store is written by create and read back by start.
  tts_ram #(
    .WIDTH(tts_pkg::DescW),
    .DEPTH(NUM_SLOTS)
  ) u_desc_ram (
    .clk    (clk),
    .wr_en  (ram_wr),
    .wr_addr(ptr),
    .wr_data(desc_q),
    .rd_addr(tid_idx),
    .rd_data(rd_data)
  );

  // Shared probe: the one test applied to the element under the scan pointer.
  always_comb begin
    unique case (state)
      S_CREATE: probe = !created_q[ptr] && !ready_q[ptr];
      S_STACK:  probe = !bitmap[step[StkW-1:0]];
      S_TICK:   probe = ready_q[ptr];
      default:  probe = 1'b0;
    endcase
  end

  always_comb begin
    state_next  = state;
    ptr_next    = ptr;
    step_next   = step;
    cur_next    = cur;
    fin         = 1'b0;
    set_created = 1'b0;
    set_ready   = 1'b0;
    res_next    = '0;
    res_next.status = tts_pkg::STATUS_OK;
    unique case (state)
      S_IDLE: begin
        if (go) begin
          unique case (req.kind)
            tts_pkg::KIND_CREATE: begin
              ptr_next   = '0;
              step_next  = '0;
              state_next = S_CREATE;
            end
            tts_pkg::KIND_START: begin
              state_next = S_CHECK;
            end
            tts_pkg::KIND_TICK: begin
              ptr_next   = cur_adv;
              step_next  = '0;
              state_next = S_TICK;
            end
            tts_pkg::KIND_NONE: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_CREATE: begin
        if (probe) begin
          fin           = 1'b1;
          set_created   = 1'b1;
          res_next.slot = tts_pkg::IdxW'(ptr);
        end else if (last_slot) begin
          fin             = 1'b1;
          res_next.status = tts_pkg::STATUS_NO_SLOT;
        end else begin
          ptr_next  = ptr_adv;
          step_next = step + 1'b1;
        end
      end
      S_CHECK: begin
        if (tid_q >= tts_pkg::TaskIdW'(NUM_SLOTS)) begin
          fin             = 1'b1;
          res_next.status = tts_pkg::STATUS_RANGE;
        end else if (!created_q[tid_idx]) begin
          fin             = 1'b1;
          res_next.status = tts_pkg::STATUS_NOT_CREATED;
          res_next.slot   = tid_q[tts_pkg::IdxW-1:0];
        end else begin
          step_next  = '0;
          state_next = S_STACK;
        end
      end
      S_STACK: begin
        if (probe) begin
          fin                   = 1'b1;
          set_ready             = 1'b1;
          res_next.slot         = tid_q[tts_pkg::IdxW-1:0];
          res_next.stack_index  = tts_pkg::IdxW'(step);
          res_next.entry_handle = rd_data;
        end else if (last_stack) begin
          fin             = 1'b1;
          res_next.status = tts_pkg::STATUS_NO_STACK;
          res_next.slot   = tid_q[tts_pkg::IdxW-1:0];
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_TICK: begin
        if (probe) begin
          fin                = 1'b1;
          cur_next           = ptr;
          res_next.switched  = 1'b1;
          res_next.from_task = tts_pkg::IdxW'(cur);
          res_next.to_task   = tts_pkg::IdxW'(ptr);
        end else if (last_slot) begin
          fin                = 1'b1;
          res_next.status    = tts_pkg::STATUS_NO_READY;
          res_next.from_task = tts_pkg::IdxW'(cur);
          res_next.to_task   = tts_pkg::IdxW'(cur);
        end else begin
          ptr_next  = ptr_adv;
          step_next = step + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = S_IDLE;
    end
    res_next.done = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      step      <= '0;
      cur       <= '0;
      created_q <= '0;
      ready_q   <= '0;
      bitmap    <= '0;
      rsp.done  <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      step     <= step_next;
      cur      <= cur_next;
      if (fin) begin
        rsp <= res_next;
      end else begin
        rsp.done <= 1'b0;
      end
      if (set_created) begin
        created_q[ptr] <= 1'b1;
      end
      if (set_ready) begin
        created_q[tid_idx]         <= 1'b0;
        ready_q[tid_idx]           <= 1'b1;
        bitmap[step[StkW-1:0]]     <= 1'b1;
      end
    end
    if (go) begin
      tid_q  <= req.task_id;
      desc_q <= req.descriptor;
    end
  end

`ifndef SYNTHESIS
  a_state_excl: assert property (@(posedge clk) disable iff (rst)
    (created_q & ready_q) == '0)
    else $error("slot is both created and ready");

  a_stack_count: assert property (@(posedge clk) disable iff (rst)
    $countones(bitmap) == $countones(ready_q))
    else $error("stacks in use do not match ready tasks");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("result strobe held for two cycles");

  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    go |-> (state == S_IDLE) && !rsp.done)
    else $error("request taken while sequencer busy");
`endif

endmodule

// ===== hdl/task_table_round_robin_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Task table round-robin scheduler core
// Task slot table with a bitmap stack allocator and a round-robin tick
// scheduler, behind valid/stall transaction ports.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and gives exactly one result for
// it. A create probes slots from slot 0 until the first empty slot or the end
// of the table, a start runs a check and, if it passes, probes stacks from
// stack 0 until a free one or the last stack, and a tick probes slots from
// the slot after the current task around to the current task. The unused
// operation code needs no probe at all. Each result then passes through the
// sequencer's result register and the output register. The single probe in
// the sequencer examines one slot or one stack per cycle. in_stall is high
// while a transaction is in work and while a finished result waits on a
// stalled output; no item is taken until the result of the previous one has
// been passed on. Descriptors live in a small RAM written by create and read
// by start; its entries need no clearing because start only reads slots that
// create has filled.
// ----------------------------------------------------------------------------
module task_table_round_robin_scheduler_core #(
  parameter int unsigned NUM_SLOTS  = 8,
  parameter int unsigned NUM_STACKS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  task_id,
  input  logic [15:0] descriptor,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [2:0]  slot,
  output logic [2:0]  stack_index,
  output logic [15:0] entry_handle,
  output logic        switched,
  output logic [2:0]  from_task,
  output logic [2:0]  to_task
);

  logic          go;
  logic          busy;
  tts_pkg::req_t req;
  tts_pkg::rsp_t rsp;

  // A request is taken only when the sequencer is idle and the output
  // register is free or being emptied in this same cycle.
  assign in_stall = busy || (out_valid && out_stall);
  assign go       = in_valid && !in_stall;

  assign req.kind       = tts_pkg::kind_t'(kind);
  assign req.task_id    = task_id;
  assign req.descriptor = descriptor;

  tts_seq #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_STACKS(NUM_STACKS)
  ) u_seq (
    .clk (clk),
    .rst (rst),
    .go  (go),
    .req (req),
    .busy(busy),
    .rsp (rsp)
  );

  // Output register. A new result can only arrive once the previous one has
  // left, since no request is taken while a result is stuck here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (rsp.done) begin
      status       <= rsp.status;
      slot         <= rsp.slot;
      stack_index  <= rsp.stack_index;
      entry_handle <= rsp.entry_handle;
      switched     <= rsp.switched;
      from_task    <= rsp.from_task;
      to_task      <= rsp.to_task;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task table scheduler testbench
// Sends create, start and tick transactions into the scheduler core and
// predicts every result from a private copy of the slot table, the stack
// bitmap and the current task. Each result is compared field by field.
// Both sides idle and stall at random in changing phases. There are two long
// receiver hold-offs and two points where the sender waits until the block
// has drained.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SLOTS          = 8;
  localparam int STACKS         = 8;
  localparam int RANDOM_ITEMS   = 875;
  localparam int HOLDOFF_CYCLES = 150;
  // No correct run goes this long without a transaction on either side. The
  // worst case is the hold-off plus one item plus random stalls.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;

  // Slot life cycle as the scheduler sees it. Slots are never freed.
  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_CREATED = 2'd1,
    SLOT_READY   = 2'd2
  } slot_state_t;

  // One request, together with how the sender and receiver behave around it.
  typedef struct {
    tts_pkg::kind_t kind;
    logic [7:0]     task_id;
    logic [15:0]    descriptor;
    int             mode;
    bit             hold_after;
    bit             drain_first;
  } sched_req_t;

  typedef struct packed {
    tts_pkg::status_t status;
    logic [2:0]       slot;
    logic [2:0]       stack_index;
    logic [15:0]      entry_handle;
    logic             switched;
    logic [2:0]       from_task;
    logic [2:0]       to_task;
  } sched_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = '0;
  logic [7:0]  task_id = '0;
  logic [15:0] descriptor = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic [2:0]  stack_index;
  logic [15:0] entry_handle;
  logic        switched;
  logic [2:0]  from_task;
  logic [2:0]  to_task;

  // The predictor's own view of the block.
  slot_state_t       tbl_state [SLOTS];
  logic [15:0]       tbl_desc [SLOTS];
  logic [STACKS-1:0] stacks_used;
  logic [2:0]        running_task;

  sched_req_t request_backlog[$];
  sched_rsp_t predicted_results[$];
  sched_req_t offer;
  int         queued_total = 0;
  int         issued_count = 0;
  int         retired_count = 0;
  int         mismatch_count = 0;
  int         active_mode = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  logic       hold_trigger = 1'b0;

  task_table_round_robin_scheduler_core #(
    .NUM_SLOTS (SLOTS),
    .NUM_STACKS(STACKS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .task_id     (task_id),
    .descriptor  (descriptor),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot        (slot),
    .stack_index (stack_index),
    .entry_handle(entry_handle),
    .switched    (switched),
    .from_task   (from_task),
    .to_task     (to_task)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idling phases: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly.
  function automatic int idle_pct(input int mode, input bit receiver);
    case (mode)
      1:       return receiver ? 0 : 57;
      2:       return receiver ? 57 : 0;
      3:       return 18;
      default: return 0;
    endcase
  endfunction

  // Works out the result of one accepted transaction and updates the table.
  // Fields that the operation does not set stay zero.
  function automatic sched_rsp_t schedule_predict(input sched_req_t r);
    sched_rsp_t res;
    bit         found;
    int         q;
    res = '0;
    found = 1'b0;
    case (r.kind)
      tts_pkg::KIND_CREATE: begin
        // The lowest empty slot is claimed; a full table reports no slot.
        res.status = tts_pkg::STATUS_NO_SLOT;
        for (q = 0; q < SLOTS; q++) begin
          if (!found && tbl_state[q] == SLOT_EMPTY) begin
            found = 1'b1;
            tbl_state[q] = SLOT_CREATED;
            tbl_desc[q] = r.descriptor;
            res.status = tts_pkg::STATUS_OK;
            res.slot = q[2:0];
          end
        end
      end
      tts_pkg::KIND_START: begin
        if (r.task_id >= SLOTS) begin
          res.status = tts_pkg::STATUS_RANGE;
        end else begin
          res.slot = r.task_id[2:0];
          if (tbl_state[r.task_id] != SLOT_CREATED) begin
            res.status = tts_pkg::STATUS_NOT_CREATED;
          end else begin
            // Lowest free stack from the bitmap; the slot is left untouched
            // when every stack is taken.
            res.status = tts_pkg::STATUS_NO_STACK;
            for (q = 0; q < STACKS; q++) begin
              if (!found && !stacks_used[q]) begin
                found = 1'b1;
                stacks_used[q] = 1'b1;
                tbl_state[r.task_id] = SLOT_READY;
                res.status = tts_pkg::STATUS_OK;
                res.stack_index = q[2:0];
                res.entry_handle = tbl_desc[r.task_id];
              end
            end
          end
        end
      end
      tts_pkg::KIND_TICK: begin
        // The scan starts after the current task and checks it last, so a
        // lone ready current task is picked again with switched set.
        res.status = tts_pkg::STATUS_NO_READY;
        res.from_task = running_task;
        res.to_task = running_task;
        for (q = 1; q <= SLOTS; q++) begin
          if (!found && tbl_state[(running_task + q) % SLOTS] == SLOT_READY) begin
            found = 1'b1;
            res.status = tts_pkg::STATUS_OK;
            res.switched = 1'b1;
            res.to_task = 3'((running_task + q) % SLOTS);
          end
        end
        running_task = res.to_task;
      end
      default: res.status = tts_pkg::STATUS_OK;
    endcase
    return res;
  endfunction

  // Appends one request. The phase of idling follows the position in the run
  // in stretches of 64, and a few fixed positions carry the hold-off and the
  // drain points.
  task automatic add_request(input tts_pkg::kind_t k, input logic [7:0] id,
                             input logic [15:0] desc);
    sched_req_t r;
    r.kind = k;
    r.task_id = id;
    r.descriptor = desc;
    r.mode = (queued_total / 64) % 4;
    r.hold_after = (queued_total == 200) || (queued_total == 640);
    r.drain_first = (queued_total == 25) || (queued_total == 420);
    request_backlog.push_back(r);
    queued_total++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver. A transaction is taken when valid is high and stall is low at the
  // edge; the prediction is made right then, so the expected results queue up
  // in acceptance order. A new request is only offered once the previous one
  // is gone, so valid never drops while an item waits on a stall.
  always @(posedge clk) begin : driver
    logic took;
    took = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
      hold_trigger <= 1'b0;
    end else begin
      if (took) begin
        predicted_results.push_back(schedule_predict(offer));
        issued_count <= issued_count + 1;
      end
      hold_trigger <= took && offer.hold_after;
      if (!in_valid || took) begin
        // A drain point holds the next request back until every result
        // issued so far has been passed on.
        if (request_backlog.size() != 0 &&
            !(request_backlog[0].drain_first && (took || issued_count != retired_count)) &&
            $urandom_range(99) >= idle_pct(request_backlog[0].mode, 1'b0)) begin
          offer = request_backlog.pop_front();
          in_valid <= 1'b1;
          kind <= offer.kind;
          task_id <= offer.task_id;
          descriptor <= offer.descriptor;
          active_mode <= offer.mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by the driver after selected requests.
  // While it runs the sender keeps offering, so the block fills and stalls.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_trigger) begin
      hold_left <= HOLDOFF_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor. Every result taken from the block is matched against the oldest
  // prediction; then the stall for the next cycle is chosen.
  always @(posedge clk) begin : monitor
    sched_rsp_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        retired_count <= retired_count + 1;
        if (predicted_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d", $time, status);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("status", 16'(want.status), 16'(status));
          check_field("slot", 16'(want.slot), 16'(slot));
          check_field("stack_index", 16'(want.stack_index), 16'(stack_index));
          check_field("entry_handle", want.entry_handle, entry_handle);
          check_field("switched", 16'(want.switched), 16'(switched));
          check_field("from_task", 16'(want.from_task), 16'(from_task));
          check_field("to_task", 16'(want.to_task), 16'(to_task));
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct(active_mode, 1'b1));
    end
  end

  // Watchdog on cycles without any transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int pick;
    for (n = 0; n < SLOTS; n++) begin
      tbl_state[n] = SLOT_EMPTY;
      tbl_desc[n] = '0;
    end
    stacks_used = '0;
    running_task = '0;

    // Directed part. On an empty table a tick finds nothing ready and starts
    // fail, both for an empty slot and for ids past the table.
    add_request(tts_pkg::KIND_TICK, 8'h00, 16'h0000);
    add_request(tts_pkg::KIND_START, 8'h00, 16'h0000);
    add_request(tts_pkg::KIND_START, 8'hFF, 16'hFFFF);
    add_request(tts_pkg::KIND_START, 8'd8, 16'h0000);
    add_request(tts_pkg::KIND_NONE, 8'hAA, 16'h5555);
    // First task: created with an all-ones handle, started, then started a
    // second time, which must be refused because it is already ready.
    add_request(tts_pkg::KIND_CREATE, 8'h55, 16'hFFFF);
    add_request(tts_pkg::KIND_START, 8'd0, 16'hAAAA);
    add_request(tts_pkg::KIND_START, 8'd0, 16'h0000);
    // Only the current task is ready, so the tick picks it again.
    add_request(tts_pkg::KIND_TICK, 8'h00, 16'h0000);
    add_request(tts_pkg::KIND_CREATE, 8'h00, 16'h0000);
    add_request(tts_pkg::KIND_CREATE, 8'hFF, 16'hA5C3);
    add_request(tts_pkg::KIND_START, 8'd2, 16'h0000);
    add_request(tts_pkg::KIND_TICK, 8'h00, 16'h0000);
    add_request(tts_pkg::KIND_TICK, 8'h00, 16'h0000);
    add_request(tts_pkg::KIND_START, 8'd7, 16'h0000);
    add_request(tts_pkg::KIND_NONE, 8'hFF, 16'hFFFF);
    add_request(tts_pkg::KIND_CREATE, 8'h80, 16'h1234);
    add_request(tts_pkg::KIND_START, 8'd1, 16'h0000);
    add_request(tts_pkg::KIND_TICK, 8'h00, 16'h0000);
    add_request(tts_pkg::KIND_START, 8'd9, 16'h0000);
    add_request(tts_pkg::KIND_TICK, 8'h00, 16'h0000);

    // Random part. Creates are rare so the table fills slowly and ticks see
    // many different sets of ready slots before it saturates; once full,
    // creates run into the no-free-slot case.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        add_request(tts_pkg::KIND_CREATE, 8'($urandom), 16'($urandom));
      end else if (pick < 14) begin
        add_request(tts_pkg::KIND_START, 8'($urandom_range(SLOTS - 1)), 16'($urandom));
      end else if (pick < 17) begin
        add_request(tts_pkg::KIND_START, 8'($urandom_range(255, SLOTS)), 16'($urandom));
      end else if (pick < 19) begin
        add_request(tts_pkg::KIND_NONE, 8'($urandom), 16'($urandom));
      end else begin
        add_request(tts_pkg::KIND_TICK, 8'($urandom), 16'($urandom));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for the backlog to be sent and every result to come back, then
    // give the block a little time to show any stray result.
    do begin
      @(negedge clk);
    end while (request_backlog.size() != 0 || in_valid || issued_count != retired_count);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, predicted_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tts_pkg.sv
hdl/tts_ram.sv
hdl/tts_seq.sv
hdl/task_table_round_robin_scheduler_core.sv
dv/tb_top.sv
